@@ sv/dsa_pkg.sv @@
// Shared types, constants and helper functions of the descriptor slot allocator.
package dsa_pkg;

	localparam int unsigned SLOT_COUNT_DEF    = 8192;
	localparam int unsigned FIRST_ALLOCATABLE = 3;
	localparam int unsigned IDX_W             = 13;
	localparam int unsigned SEL_W             = 16;
	localparam int unsigned CNT_W             = 14;
	localparam int unsigned BIT_W             = 6;
	localparam int unsigned WORD_W            = 64;
	localparam int unsigned WIDX_W            = IDX_W - BIT_W;
	localparam int unsigned GRP_SIZE          = 16;
	localparam logic [CNT_W-1:0] USED_RESET   = CNT_W'(2);
	localparam logic [IDX_W-1:0] SYS_SLOT_A   = IDX_W'(1);
	localparam logic [IDX_W-1:0] SYS_SLOT_B   = IDX_W'(2);

	localparam logic [1:0] MODE_ALLOC = 2'd0;
	localparam logic [1:0] MODE_FREE  = 2'd1;
	localparam logic [1:0] MODE_BUSY  = 2'd2;

	typedef struct packed {
		logic [1:0]       mode;
		logic [SEL_W-1:0] selector_in;
		logic [IDX_W-1:0] entry_index;
	} req_t;

	typedef struct packed {
		logic [SEL_W-1:0] selector_out;
		logic             found;
		logic [CNT_W-1:0] used_count;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_GRP,
		ST_WRD,
		ST_RD,
		ST_LD,
		ST_CHK,
		ST_BIT,
		ST_WR,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic load;
		logic grp_pick;
		logic wrd_pick;
		logic rd;
		logic ld;
		logic chk;
		logic bit_pick;
		logic wr;
		logic resp;
	} cmd_t;

	typedef struct packed {
		logic req_alloc;
		logic req_mod;
		logic alloc_q;
		logic grp_found;
	} stat_t;

	function automatic logic [3:0] lowest16(input logic [GRP_SIZE-1:0] v);
		logic [3:0] r;
		r = '0;
		for (int i = GRP_SIZE - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = 4'(i);
			end
		end
		return r;
	endfunction

	function automatic logic [WORD_W-1:0] reset_word(input logic [WIDX_W-1:0] w,
		input int unsigned slots);
		logic [WORD_W-1:0] r;
		logic [IDX_W-1:0]  s;
		r = '0;
		for (int b = 0; b < WORD_W; b++) begin
			s    = {w, BIT_W'(b)};
			r[b] = (32'(s) < slots) && (s != SYS_SLOT_A) && (s != SYS_SLOT_B);
		end
		return r;
	endfunction

	function automatic logic [WORD_W-1:0] alloc_mask(input logic [WIDX_W-1:0] w);
		logic [WORD_W-1:0] r;
		r = '1;
		if (w == '0) begin
			r = ~((WORD_W'(1) << FIRST_ALLOCATABLE) - WORD_W'(1));
		end
		return r;
	endfunction

endpackage

@@ sv/descriptor_slot_allocator_unit.sv @@
// Top level of the descriptor slot allocator: controller plus datapath.
// Allocate: group pick, word pick, read, load, chunk check, bit pick, write (a full table
// ends after the group search); free and mark-busy: read, load, write; an unknown mode or
// out-of-range slot goes straight to the response. One transfer at a time: busy is high
// until rsp is loaded; the next start is taken when done is shown; rsp holds until replaced.
// Reset: asynchronous, slots 1 and 2 busy, all others free, used count 2; no clearing pass.
module descriptor_slot_allocator_unit #(
	parameter int unsigned SLOT_COUNT = dsa_pkg::SLOT_COUNT_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  dsa_pkg::req_t req,
	output logic          done,
	output dsa_pkg::rsp_t rsp
);

	dsa_pkg::cmd_t  cmd;
	dsa_pkg::stat_t stat;

	dsa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	dsa_datapath #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.rsp    (rsp),
		.done   (done)
	);

endmodule

@@ sv/dsa_ctrl.sv @@
// Sequencing state machine of the descriptor slot allocator.
module dsa_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  dsa_pkg::stat_t stat,
	output dsa_pkg::cmd_t  cmd
);

	dsa_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dsa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			dsa_pkg::ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (stat.req_alloc) begin
						state_d = dsa_pkg::ST_GRP;
					end else if (stat.req_mod) begin
						state_d = dsa_pkg::ST_RD;
					end else begin
						state_d = dsa_pkg::ST_RESP;
					end
				end
			end
			dsa_pkg::ST_GRP: begin
				cmd.grp_pick = 1'b1;
				state_d      = dsa_pkg::ST_WRD;
			end
			dsa_pkg::ST_WRD: begin
				if (stat.grp_found) begin
					cmd.wrd_pick = 1'b1;
					state_d      = dsa_pkg::ST_RD;
				end else begin
					state_d = dsa_pkg::ST_RESP;
				end
			end
			dsa_pkg::ST_RD: begin
				cmd.rd  = 1'b1;
				state_d = dsa_pkg::ST_LD;
			end
			dsa_pkg::ST_LD: begin
				cmd.ld  = 1'b1;
				state_d = stat.alloc_q ? dsa_pkg::ST_CHK : dsa_pkg::ST_WR;
			end
			dsa_pkg::ST_CHK: begin
				cmd.chk = 1'b1;
				state_d = dsa_pkg::ST_BIT;
			end
			dsa_pkg::ST_BIT: begin
				cmd.bit_pick = 1'b1;
				state_d      = dsa_pkg::ST_WR;
			end
			dsa_pkg::ST_WR: begin
				cmd.wr  = 1'b1;
				state_d = dsa_pkg::ST_IDLE;
			end
			dsa_pkg::ST_RESP: begin
				cmd.resp = 1'b1;
				state_d  = dsa_pkg::ST_IDLE;
			end
			default: begin
				state_d = dsa_pkg::ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != dsa_pkg::ST_IDLE);

endmodule

@@ sv/dsa_datapath.sv @@
// Free bitmap memory, summary flags, first-fit search and used counter.
module dsa_datapath #(
	parameter int unsigned SLOT_COUNT = dsa_pkg::SLOT_COUNT_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  dsa_pkg::req_t  req,
	input  dsa_pkg::cmd_t  cmd,
	output dsa_pkg::stat_t stat,
	output dsa_pkg::rsp_t  rsp,
	output logic           done
);

	localparam int unsigned WORDS   = (SLOT_COUNT + dsa_pkg::WORD_W - 1) / dsa_pkg::WORD_W;
	localparam int unsigned WADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int unsigned NGRP    = (WORDS + dsa_pkg::GRP_SIZE - 1) / dsa_pkg::GRP_SIZE;
	localparam int unsigned GRP_W   = (NGRP > 1) ? $clog2(NGRP) : 1;
	localparam int unsigned SUM_W   = NGRP * dsa_pkg::GRP_SIZE;
	localparam int unsigned NCHK    = dsa_pkg::WORD_W / dsa_pkg::GRP_SIZE;

	logic [dsa_pkg::WORD_W-1:0]  mem_q [WORDS];
	logic [WORDS-1:0]            valid_q;
	logic [WORDS-1:0]            summary_q;
	logic [dsa_pkg::WORD_W-1:0]  rdata_q;
	logic                        rvld_q;
	logic [dsa_pkg::WORD_W-1:0]  word_q;
	logic [dsa_pkg::IDX_W-1:0]   slot_q;
	logic [1:0]                  mode_q;
	logic [GRP_W-1:0]            grp_q;
	logic                        grp_found_q;
	logic [1:0]                  chunk_q;
	logic [dsa_pkg::CNT_W-1:0]   used_q;
	dsa_pkg::rsp_t               rsp_q;
	logic                        done_q;

	logic [dsa_pkg::IDX_W-1:0]   req_slot;
	logic [SUM_W-1:0]            summary_pad;
	logic [NGRP-1:0]             grp_flags;
	logic [GRP_W-1:0]            grp_sel;
	logic [WADDR_W-1:0]          addr;
	logic [dsa_pkg::WIDX_W-1:0]  widx;
	logic [dsa_pkg::WORD_W-1:0]  masked;
	logic [NCHK-1:0]             chk_flags;
	logic [1:0]                  chk_sel;
	logic                        new_bit;
	logic                        old_bit;
	logic [dsa_pkg::WORD_W-1:0]  new_word;
	logic [dsa_pkg::IDX_W-1:0]   found_slot;

	assign req_slot = (req.mode == dsa_pkg::MODE_FREE) ?
		req.selector_in[dsa_pkg::SEL_W-1:3] : req.entry_index;

	assign stat.req_alloc = (req.mode == dsa_pkg::MODE_ALLOC);
	assign stat.req_mod   = ((req.mode == dsa_pkg::MODE_FREE) ||
		(req.mode == dsa_pkg::MODE_BUSY)) &&
		((dsa_pkg::CNT_W)'(req_slot) < (dsa_pkg::CNT_W)'(SLOT_COUNT));
	assign stat.alloc_q   = (mode_q == dsa_pkg::MODE_ALLOC);
	assign stat.grp_found = grp_found_q;

	assign summary_pad = SUM_W'(summary_q);
	assign widx        = slot_q[dsa_pkg::IDX_W-1:dsa_pkg::BIT_W];
	assign addr        = slot_q[dsa_pkg::BIT_W +: WADDR_W];

	always_comb begin
		grp_sel = '0;
		for (int g = 0; g < NGRP; g++) begin
			grp_flags[g] = |summary_pad[g*dsa_pkg::GRP_SIZE +: dsa_pkg::GRP_SIZE];
		end
		for (int g = NGRP - 1; g >= 0; g--) begin
			if (grp_flags[g]) begin
				grp_sel = GRP_W'(g);
			end
		end
	end

	assign masked = word_q & dsa_pkg::alloc_mask(widx);

	always_comb begin
		chk_sel = '0;
		for (int c = 0; c < NCHK; c++) begin
			chk_flags[c] = |masked[c*dsa_pkg::GRP_SIZE +: dsa_pkg::GRP_SIZE];
		end
		for (int c = NCHK - 1; c >= 0; c--) begin
			if (chk_flags[c]) begin
				chk_sel = 2'(c);
			end
		end
	end

	assign new_bit = (mode_q == dsa_pkg::MODE_FREE);
	assign old_bit = word_q[slot_q[dsa_pkg::BIT_W-1:0]];

	always_comb begin
		new_word = word_q;
		new_word[slot_q[dsa_pkg::BIT_W-1:0]] = new_bit;
	end

	assign found_slot = slot_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= req.mode;
			slot_q <= req_slot;
		end
		if (cmd.grp_pick) begin
			grp_q <= grp_sel;
		end
		if (cmd.wrd_pick) begin
			slot_q <= {dsa_pkg::WIDX_W'({grp_q,
				dsa_pkg::lowest16(summary_pad[{grp_q, 4'b0000} +: dsa_pkg::GRP_SIZE])}),
				dsa_pkg::BIT_W'(0)};
		end
		if (cmd.rd) begin
			rdata_q <= mem_q[addr];
			rvld_q  <= valid_q[addr];
		end
		if (cmd.ld) begin
			word_q <= rvld_q ? rdata_q : dsa_pkg::reset_word(widx, SLOT_COUNT);
		end
		if (cmd.chk) begin
			chunk_q <= chk_sel;
		end
		if (cmd.bit_pick) begin
			slot_q[dsa_pkg::BIT_W-1:0] <= {chunk_q,
				dsa_pkg::lowest16(masked[{chunk_q, 4'b0000} +: dsa_pkg::GRP_SIZE])};
		end
		if (cmd.wr) begin
			mem_q[addr] <= new_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_found_q <= 1'b0;
			valid_q     <= '0;
			summary_q   <= '1;
			used_q      <= dsa_pkg::USED_RESET;
			done_q      <= 1'b0;
		end else begin
			done_q <= cmd.wr || cmd.resp;
			if (cmd.grp_pick) begin
				grp_found_q <= |grp_flags;
			end
			if (cmd.wr) begin
				valid_q[addr]   <= 1'b1;
				summary_q[addr] <= |(new_word & dsa_pkg::alloc_mask(widx));
				if (old_bit && !new_bit) begin
					used_q <= used_q + dsa_pkg::CNT_W'(1);
				end else if (!old_bit && new_bit) begin
					used_q <= used_q - dsa_pkg::CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			rsp_q.selector_out <= (mode_q == dsa_pkg::MODE_ALLOC) ?
				{found_slot, 3'b000} : '0;
			rsp_q.found        <= (mode_q == dsa_pkg::MODE_ALLOC);
			if (old_bit && !new_bit) begin
				rsp_q.used_count <= used_q + dsa_pkg::CNT_W'(1);
			end else if (!old_bit && new_bit) begin
				rsp_q.used_count <= used_q - dsa_pkg::CNT_W'(1);
			end else begin
				rsp_q.used_count <= used_q;
			end
		end else if (cmd.resp) begin
			rsp_q.selector_out <= '0;
			rsp_q.found        <= 1'b0;
			rsp_q.used_count   <= used_q;
		end
	end

	assign rsp  = rsp_q;
	assign done = done_q;

endmodule
